### rtl/mair_pkg.sv
// ----------------------------------------------------------------------------
// mair_pkg
// Shared types, constants and helpers for the missing-aware int64 reduction
// core: mode codes, the queued item format and the accumulator identities.
// ----------------------------------------------------------------------------
package mair_pkg;

    // Value width and special codes.
    localparam int VALUE_W = 64;
    localparam logic signed [VALUE_W-1:0] MISSING_CODE = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] POS_LIMIT    = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] NEG_LIMIT    = {1'b1, {(VALUE_W-2){1'b0}}, 1'b1};

    // Configuration port.
    localparam int CFG_DATA_W = 3;

    typedef enum logic {
        REG_MODE = 1'b0,
        REG_SKIP = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic                  we;
        t_cfg_reg              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Reduction modes; code 7 is folded into sum when written.
    typedef enum logic [2:0] {
        MODE_SUM   = 3'd0,
        MODE_PROD  = 3'd1,
        MODE_MIN   = 3'd2,
        MODE_MAX   = 3'd3,
        MODE_RANGE = 3'd4,
        MODE_ANY   = 3'd5,
        MODE_ALL   = 3'd6
    } t_mode;

    // Item as classified by the front part.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      missing;
        logic                      zero;
    } t_item;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Product sequencer: four partial products, then the final sum.
    typedef logic [2:0] t_step;
    localparam t_step MUL_DONE = 3'd5;

    // Identity of the first accumulator for a mode.
    function automatic logic signed [VALUE_W-1:0] ident_first(input t_mode mode);
        logic signed [VALUE_W-1:0] r;
        case (mode)
            MODE_PROD:  r = {{(VALUE_W-1){1'b0}}, 1'b1};
            MODE_MIN:   r = POS_LIMIT;
            MODE_MAX:   r = NEG_LIMIT;
            MODE_RANGE: r = POS_LIMIT;
            default:    r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/mair_front.sv
// ----------------------------------------------------------------------------
// mair_front
// Input stage: registers each accepted item and tags it as missing and/or
// zero before handing it to the queue.
// ----------------------------------------------------------------------------
module mair_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [mair_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_last,
    output logic                                o_push,
    output mair_pkg::t_item                     o_item,
    input  logic                                i_push_ready
);

    logic            r_valid;
    logic            n_valid;
    mair_pkg::t_item r_item;
    logic            w_accept;

    // The stage takes a new item when empty or when its item moves on.
    assign o_push   = r_valid && i_push_ready;
    assign o_ready  = !r_valid || i_push_ready;
    assign w_accept = i_valid && o_ready;
    assign o_item   = r_item;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Classification of the payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.value   <= i_value;
            r_item.last    <= i_last;
            r_item.missing <= (i_value == mair_pkg::MISSING_CODE);
            r_item.zero    <= (i_value == '0);
        end
    end

endmodule

### rtl/mair_queue.sv
// ----------------------------------------------------------------------------
// mair_queue
// Small register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module mair_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mair_pkg::t_item i_item,
    output logic            o_push_ready,
    output logic            o_valid,
    output mair_pkg::t_item o_item,
    input  logic            i_pop
);

    mair_pkg::t_item                   r_mem [mair_pkg::QUEUE_DEPTH];
    logic [mair_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [mair_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [mair_pkg::QCNT_W-1:0]       r_count;
    logic [mair_pkg::QPTR_W-1:0]       n_wr_ptr;
    logic [mair_pkg::QPTR_W-1:0]       n_rd_ptr;
    logic [mair_pkg::QCNT_W-1:0]       n_count;

    localparam logic [mair_pkg::QPTR_W-1:0] PTR_LAST = mair_pkg::QPTR_W'(mair_pkg::QUEUE_DEPTH - 1);
    localparam logic [mair_pkg::QCNT_W-1:0] CNT_FULL = mair_pkg::QCNT_W'(mair_pkg::QUEUE_DEPTH);

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_valid      = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/mair_back.sv
// ----------------------------------------------------------------------------
// mair_back
// Execution part: holds the configuration and the accumulators, folds each
// queued item into them, runs the multi-cycle product and drives the result
// register.
// ----------------------------------------------------------------------------
module mair_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mair_pkg::t_cfg_wr                   i_cfg,
    input  logic                                i_q_valid,
    input  mair_pkg::t_item                     i_q_item,
    output logic                                o_q_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [mair_pkg::VALUE_W-1:0] o_result_first,
    output logic signed [mair_pkg::VALUE_W-1:0] o_result_second,
    output logic                                o_result_missing,
    output logic                                o_overflowed
);

    localparam int W = mair_pkg::VALUE_W;
    localparam int H = W / 2;

    // Configuration.
    mair_pkg::t_mode r_mode;
    logic            r_skip;
    mair_pkg::t_mode n_mode;
    logic            n_skip;

    // Accumulators.
    logic signed [W-1:0] r_acc_first;
    logic signed [W-1:0] r_acc_second;
    logic                r_seen;
    logic                r_decided;
    logic                r_ovf;
    logic signed [W-1:0] n_acc_first;
    logic signed [W-1:0] n_acc_second;
    logic                n_seen;
    logic                n_decided;
    logic                n_ovf;

    // Product sequencer.
    logic                 r_busy;
    mair_pkg::t_step      r_step;
    logic [W-1:0]         r_ma;
    logic [W-1:0]         r_mv;
    logic                 r_neg;
    logic [W-1:0]         r_pp;
    logic [2*W-1:0]       r_prod;
    logic [H-1:0]         w_mul_a;
    logic [H-1:0]         w_mul_b;
    logic [2*W-1:0]       w_pp_shift;
    logic                 w_p_ovf;
    logic signed [W-1:0]  w_p_val;

    // Result register.
    logic                r_out_valid;
    logic signed [W-1:0] r_out_first;
    logic signed [W-1:0] r_out_second;
    logic                r_out_missing;
    logic                r_out_ovf;
    logic signed [W-1:0] n_out_first;
    logic signed [W-1:0] n_out_second;
    logic                n_out_missing;
    logic                n_out_ovf;

    // Control.
    logic                need_mul;
    logic                mul_done;
    logic                start_mul;
    logic                out_free;
    logic                pop;
    logic                w_any_all;
    logic [W:0]          w_sum;
    logic                w_sum_ovf;

    assign o_valid          = r_out_valid;
    assign o_result_first   = r_out_first;
    assign o_result_second  = r_out_second;
    assign o_result_missing = r_out_missing;
    assign o_overflowed     = r_out_ovf;
    assign o_q_pop          = pop;

    // Item scheduling: a product item waits for the multiplier, a last item
    // waits for room in the result register.
    assign w_any_all = (r_mode == mair_pkg::MODE_ANY) || (r_mode == mair_pkg::MODE_ALL);
    assign need_mul  = i_q_valid && (r_mode == mair_pkg::MODE_PROD) && !r_seen && !r_ovf
                       && !i_q_item.missing;
    assign mul_done  = r_busy && (r_step == mair_pkg::MUL_DONE);
    assign start_mul = need_mul && !r_busy;
    assign out_free  = !r_out_valid || i_ready;
    assign pop       = i_q_valid && (!need_mul || mul_done) && (!i_q_item.last || out_free);

    // Configuration write decode; an unused mode code behaves as sum.
    always_comb begin
        n_mode = r_mode;
        n_skip = r_skip;
        if (i_cfg.we) begin
            case (i_cfg.idx)
                mair_pkg::REG_MODE: begin
                    if (i_cfg.data inside {[3'd0:3'd6]}) begin
                        n_mode = mair_pkg::t_mode'(i_cfg.data);
                    end else begin
                        n_mode = mair_pkg::MODE_SUM;
                    end
                end
                mair_pkg::REG_SKIP: n_skip = i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Partial product operand selection, one quarter per step.
    always_comb begin
        case (r_step)
            3'd0:    begin w_mul_a = r_ma[H-1:0]; w_mul_b = r_mv[H-1:0]; end
            3'd1:    begin w_mul_a = r_ma[H-1:0]; w_mul_b = r_mv[W-1:H]; end
            3'd2:    begin w_mul_a = r_ma[W-1:H]; w_mul_b = r_mv[H-1:0]; end
            3'd3:    begin w_mul_a = r_ma[W-1:H]; w_mul_b = r_mv[W-1:H]; end
            default: begin w_mul_a = '0;          w_mul_b = '0;          end
        endcase
        case (r_step)
            3'd1:    w_pp_shift = {{W{1'b0}}, r_pp};
            3'd2:    w_pp_shift = {{H{1'b0}}, r_pp, {H{1'b0}}};
            3'd3:    w_pp_shift = {{H{1'b0}}, r_pp, {H{1'b0}}};
            3'd4:    w_pp_shift = {r_pp, {W{1'b0}}};
            default: w_pp_shift = '0;
        endcase
    end

    // The product overflows if its magnitude exceeds the positive limit.
    assign w_p_ovf = (r_prod[2*W-1:W-1] != '0);
    assign w_p_val = r_neg ? -$signed(r_prod[W-1:0]) : $signed(r_prod[W-1:0]);

    // Sum with overflow outside the symmetric range.
    assign w_sum     = {r_acc_first[W-1], r_acc_first} + {i_q_item.value[W-1], i_q_item.value};
    assign w_sum_ovf = (w_sum[W] != w_sum[W-1]) || (w_sum[W-1:0] == mair_pkg::MISSING_CODE);

    // Accumulator update for the item at the head of the queue.
    always_comb begin
        n_acc_first  = r_acc_first;
        n_acc_second = r_acc_second;
        n_seen       = r_seen;
        n_decided    = r_decided;
        n_ovf        = r_ovf;
        if (w_any_all) begin
            if (!r_decided) begin
                if (i_q_item.missing) begin
                    n_seen = r_seen || !r_skip;
                end else if ((r_mode == mair_pkg::MODE_ANY) == !i_q_item.zero) begin
                    n_decided = 1'b1;
                end
            end
        end else if (!r_seen && !r_ovf) begin
            if (i_q_item.missing) begin
                n_seen = !r_skip;
            end else begin
                case (r_mode)
                    mair_pkg::MODE_PROD: begin
                        if (w_p_ovf) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc_first = w_p_val;
                        end
                    end
                    mair_pkg::MODE_MIN: begin
                        if (i_q_item.value < r_acc_first) n_acc_first = i_q_item.value;
                    end
                    mair_pkg::MODE_MAX: begin
                        if (i_q_item.value > r_acc_first) n_acc_first = i_q_item.value;
                    end
                    mair_pkg::MODE_RANGE: begin
                        if (i_q_item.value < r_acc_first) n_acc_first = i_q_item.value;
                        if (i_q_item.value > r_acc_second) n_acc_second = i_q_item.value;
                    end
                    default: begin
                        if (w_sum_ovf) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc_first = $signed(w_sum[W-1:0]);
                        end
                    end
                endcase
            end
        end
    end

    // Result formed from the updated accumulators.
    always_comb begin
        n_out_first   = n_acc_first;
        n_out_second  = '0;
        n_out_missing = 1'b0;
        n_out_ovf     = 1'b0;
        if (w_any_all) begin
            if (n_decided) begin
                n_out_first = (r_mode == mair_pkg::MODE_ANY) ? W'(1) : '0;
            end else if (n_seen) begin
                n_out_first   = mair_pkg::MISSING_CODE;
                n_out_missing = 1'b1;
            end else begin
                n_out_first = (r_mode == mair_pkg::MODE_ANY) ? '0 : W'(1);
            end
        end else if (n_seen || n_ovf) begin
            n_out_first   = mair_pkg::MISSING_CODE;
            n_out_missing = 1'b1;
            n_out_ovf     = n_ovf;
            if (r_mode == mair_pkg::MODE_RANGE) n_out_second = mair_pkg::MISSING_CODE;
        end else if (r_mode == mair_pkg::MODE_RANGE) begin
            n_out_second = n_acc_second;
        end
    end

    // Configuration and accumulator registers; a write or a last item
    // restarts the set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= mair_pkg::MODE_SUM;
            r_skip       <= 1'b0;
            r_acc_first  <= mair_pkg::ident_first(mair_pkg::MODE_SUM);
            r_acc_second <= mair_pkg::NEG_LIMIT;
            r_seen       <= 1'b0;
            r_decided    <= 1'b0;
            r_ovf        <= 1'b0;
        end else if (i_cfg.we || (pop && i_q_item.last)) begin
            r_mode       <= n_mode;
            r_skip       <= n_skip;
            r_acc_first  <= mair_pkg::ident_first(n_mode);
            r_acc_second <= mair_pkg::NEG_LIMIT;
            r_seen       <= 1'b0;
            r_decided    <= 1'b0;
            r_ovf        <= 1'b0;
        end else if (pop) begin
            r_acc_first  <= n_acc_first;
            r_acc_second <= n_acc_second;
            r_seen       <= n_seen;
            r_decided    <= n_decided;
            r_ovf        <= n_ovf;
        end
    end

    // Product sequencer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (pop) begin
            r_busy <= 1'b0;
        end else if (start_mul) begin
            r_busy <= 1'b1;
        end
    end

    // Product datapath: one 32x32 partial product per cycle, each added in the
    // next cycle into the 128-bit magnitude.
    always_ff @(posedge i_clk) begin
        if (start_mul) begin
            r_ma   <= r_acc_first[W-1] ? W'(-r_acc_first) : r_acc_first;
            r_mv   <= i_q_item.value[W-1] ? W'(-i_q_item.value) : i_q_item.value;
            r_neg  <= r_acc_first[W-1] ^ i_q_item.value[W-1];
            r_step <= '0;
            r_prod <= '0;
        end else if (r_busy && (r_step != mair_pkg::MUL_DONE)) begin
            r_step <= r_step + 1'b1;
            r_pp   <= w_mul_a * w_mul_b;
            r_prod <= r_prod + w_pp_shift;
        end
    end

    // Result register, freed as soon as the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && i_q_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_q_item.last) begin
            r_out_first   <= n_out_first;
            r_out_second  <= n_out_second;
            r_out_missing <= n_out_missing;
            r_out_ovf     <= n_out_ovf;
        end
    end

`ifndef SYNTH
    // An item still in the multiplier is never retired.
    a_no_pop_mid_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (need_mul && !mul_done) |-> !pop)
        else $error("item retired before its product was complete");

    // The sequencer never steps past its final count.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= mair_pkg::MUL_DONE))
        else $error("product sequencer ran past its last step");

    // A configuration write leaves a fresh set behind.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cfg.we) |-> (!r_seen && !r_decided && !r_ovf))
        else $error("set flags survived a configuration write");

    // An overflowed result is always reported as missing.
    a_ovf_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> (r_out_missing && (r_out_first == mair_pkg::MISSING_CODE)))
        else $error("overflow flag without a missing result");
`endif

endmodule

### rtl/missing_aware_int64_reduction_core.sv
// ----------------------------------------------------------------------------
// missing_aware_int64_reduction_core
// Top level of a streaming reduction over signed 64-bit values with a
// missing-value code; the front stage, queue and execution part in a row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one value per item and a last
//   flag; output channel (o_valid/i_ready) carries one result per set, given
//   for the item marked last. The configuration port (i_cfg_we, i_cfg_index,
//   i_cfg_wdata) selects the mode and the skip-missing option; a write
//   restarts the set and is made while the core is idle.
//   Throughput: one item per cycle in sum, min, max, range, any and all,
//   save that a last item waits while the result register is held.
//   In product mode each non-missing item passes through the execution part
//   in order: the magnitudes are loaded, the four 32x32 partial products of
//   the shared multiplier are formed, the last of them is added and the item
//   is retired; once a set is missing or overflowed the rest of it flows at
//   one item per cycle. A last item is registered in the front stage, then
//   in the queue, then in the result register, after any product it needs.
//   Reset (synchronous, active low) empties the pipeline, selects sum mode
//   with skip-missing off and clears the accumulators.
//   When the receiver stalls the result is held; items that are not last
//   keep flowing, and a last item waits at the head of the queue.
// ----------------------------------------------------------------------------
module missing_aware_int64_reduction_core (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic                                      i_cfg_index,
    input  logic [mair_pkg::CFG_DATA_W-1:0]           i_cfg_wdata,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic signed [mair_pkg::VALUE_W-1:0]       i_value,
    input  logic                                      i_last,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic signed [mair_pkg::VALUE_W-1:0]       o_result_first,
    output logic signed [mair_pkg::VALUE_W-1:0]       o_result_second,
    output logic                                      o_result_missing,
    output logic                                      o_overflowed
);

    mair_pkg::t_item   w_front_item;
    logic              w_front_push;
    logic              w_push_ready;
    mair_pkg::t_item   w_q_item;
    logic              w_q_valid;
    logic              w_q_pop;
    mair_pkg::t_cfg_wr w_cfg;

    // Configuration write bundle.
    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = mair_pkg::t_cfg_reg'(i_cfg_index);
    assign w_cfg.data = i_cfg_wdata;

    mair_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .i_last       (i_last),
        .o_push       (w_front_push),
        .o_item       (w_front_item),
        .i_push_ready (w_push_ready)
    );

    mair_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_front_push),
        .i_item       (w_front_item),
        .o_push_ready (w_push_ready),
        .o_valid      (w_q_valid),
        .o_item       (w_q_item),
        .i_pop        (w_q_pop)
    );

    mair_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_q_valid        (w_q_valid),
        .i_q_item         (w_q_item),
        .o_q_pop          (w_q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_first   (o_result_first),
        .o_result_second  (o_result_second),
        .o_result_missing (o_result_missing),
        .o_overflowed     (o_overflowed)
    );

endmodule

### dv/missing_aware_int64_reduction_core_tb.sv
// ----------------------------------------------------------------------------
// missing_aware_int64_reduction_core_tb
// Self-checking bench for the missing-aware int64 reduction core. It drives
// sets of values through the valid/ready input channel and predicts each
// aggregate: sum, product, min, max, range, any and all, with and without
// skip-missing. Random gaps and stalls sit on both channels. Every result is
// compared field by field with the oldest predicted aggregate.
// ----------------------------------------------------------------------------
module missing_aware_int64_reduction_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_UNUSED    = 3'd7;
    localparam logic [2:0] SKIP_ON        = 3'd1;
    localparam logic [2:0] SKIP_OFF       = 3'd0;
    localparam int         DRAIN_CYCLES   = 64;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RANDOM_PHASES  = 14;
    localparam int         ITEMS_PER_PHASE = 34;

    typedef struct {
        logic signed [mair_pkg::VALUE_W-1:0] agg_first;
        logic signed [mair_pkg::VALUE_W-1:0] agg_second;
        logic                                missing;
        logic                                overflow;
    } t_agg_result;

    // Running aggregate of the current set and the queue of aggregates
    // that the core still owes.
    class t_set_aggregate_model;
        logic [2:0]                          mode_reg;
        logic                                skip_reg;
        logic signed [mair_pkg::VALUE_W-1:0] acc_lo;
        logic signed [mair_pkg::VALUE_W-1:0] acc_hi;
        bit                                  seen_missing;
        bit                                  decided;
        bit                                  overflowed;
        t_agg_result                         pending_aggregates[$];
        int                                  errors;

        function new();
            mode_reg = mair_pkg::MODE_SUM;
            skip_reg = 1'b0;
            errors   = 0;
            restart();
        endfunction

        // The unused code falls back to sum.
        function mair_pkg::t_mode cur_mode();
            return (mode_reg > mair_pkg::MODE_ALL) ? mair_pkg::MODE_SUM
                                                   : mair_pkg::t_mode'(mode_reg);
        endfunction

        function void restart();
            case (cur_mode())
                mair_pkg::MODE_PROD:  acc_lo = 64'sd1;
                mair_pkg::MODE_MIN,
                mair_pkg::MODE_RANGE: acc_lo = mair_pkg::POS_LIMIT;
                mair_pkg::MODE_MAX:   acc_lo = mair_pkg::NEG_LIMIT;
                default:              acc_lo = '0;
            endcase
            acc_hi       = mair_pkg::NEG_LIMIT;
            seen_missing = 1'b0;
            decided      = 1'b0;
            overflowed   = 1'b0;
        endfunction

        // Any register write restarts the set in progress.
        function void write_reg(mair_pkg::t_cfg_reg idx, logic [2:0] data);
            if (idx == mair_pkg::REG_MODE) begin
                mode_reg = data;
            end else begin
                skip_reg = data[0];
            end
            restart();
        endfunction

        // Folds one accepted item into the aggregate. Returns 1 when the item
        // could still change the outcome of its set.
        function bit take_value(logic signed [mair_pkg::VALUE_W-1:0] value, logic last);
            mair_pkg::t_mode m;
            bit              is_missing;
            bit              used;
            logic [63:0]     mag_a;
            logic [63:0]     mag_v;
            logic [63:0]     prod;
            logic [63:0]     lim;
            t_agg_result     r;
            m          = cur_mode();
            is_missing = (value == mair_pkg::MISSING_CODE);
            lim        = mair_pkg::POS_LIMIT;
            if (m == mair_pkg::MODE_ANY || m == mair_pkg::MODE_ALL) begin
                used = !decided;
                if (used) begin
                    if (is_missing) begin
                        if (!skip_reg) seen_missing = 1'b1;
                    end else if ((m == mair_pkg::MODE_ANY) == (value != 0)) begin
                        decided = 1'b1;
                    end
                end
            end else begin
                used = !seen_missing && !overflowed;
                if (used && is_missing) begin
                    if (!skip_reg) seen_missing = 1'b1;
                end else if (used) begin
                    case (m)
                        mair_pkg::MODE_SUM: begin
                            if ((value > 0 && acc_lo > mair_pkg::POS_LIMIT - value) ||
                                (value < 0 && acc_lo < mair_pkg::NEG_LIMIT - value)) begin
                                overflowed = 1'b1;
                            end else begin
                                acc_lo = acc_lo + value;
                            end
                        end
                        mair_pkg::MODE_PROD: begin
                            mag_a = (acc_lo < 0) ? -acc_lo : acc_lo;
                            mag_v = (value < 0) ? -value : value;
                            if (mag_a != 0 && mag_v != 0 && mag_a > lim / mag_v) begin
                                overflowed = 1'b1;
                            end else begin
                                prod   = mag_a * mag_v;
                                acc_lo = ((acc_lo < 0) != (value < 0)) ? -$signed(prod)
                                                                       : $signed(prod);
                            end
                        end
                        mair_pkg::MODE_MIN: begin
                            if (value < acc_lo) acc_lo = value;
                        end
                        mair_pkg::MODE_MAX: begin
                            if (value > acc_lo) acc_lo = value;
                        end
                        default: begin
                            if (value < acc_lo) acc_lo = value;
                            if (value > acc_hi) acc_hi = value;
                        end
                    endcase
                end
            end

            // The last item of a set closes it and produces one aggregate.
            if (last) begin
                r.agg_second = '0;
                r.missing    = 1'b0;
                r.overflow   = 1'b0;
                if (m == mair_pkg::MODE_ANY || m == mair_pkg::MODE_ALL) begin
                    if (decided) begin
                        r.agg_first = (m == mair_pkg::MODE_ANY) ? 64'sd1 : 64'sd0;
                    end else if (seen_missing) begin
                        r.agg_first = mair_pkg::MISSING_CODE;
                        r.missing   = 1'b1;
                    end else begin
                        r.agg_first = (m == mair_pkg::MODE_ANY) ? 64'sd0 : 64'sd1;
                    end
                end else if (seen_missing || overflowed) begin
                    r.agg_first = mair_pkg::MISSING_CODE;
                    if (m == mair_pkg::MODE_RANGE) r.agg_second = mair_pkg::MISSING_CODE;
                    r.missing  = 1'b1;
                    r.overflow = overflowed;
                end else begin
                    r.agg_first = acc_lo;
                    if (m == mair_pkg::MODE_RANGE) r.agg_second = acc_hi;
                end
                pending_aggregates.push_back(r);
                restart();
            end
            return used;
        endfunction

        function void check_aggregate(logic signed [mair_pkg::VALUE_W-1:0] agg_first,
                                      logic signed [mair_pkg::VALUE_W-1:0] agg_second,
                                      logic missing, logic overflow);
            t_agg_result e;
            if (pending_aggregates.size() == 0) begin
                $error("result with no set pending: result_first %0d", agg_first);
                errors++;
            end else begin
                e = pending_aggregates.pop_front();
                if (agg_first !== e.agg_first) begin
                    $error("result_first: expected %0d, got %0d", e.agg_first, agg_first);
                    errors++;
                end
                if (agg_second !== e.agg_second) begin
                    $error("result_second: expected %0d, got %0d", e.agg_second, agg_second);
                    errors++;
                end
                if (missing !== e.missing) begin
                    $error("result_missing: expected %0d, got %0d", e.missing, missing);
                    errors++;
                end
                if (overflow !== e.overflow) begin
                    $error("overflowed: expected %0d, got %0d", e.overflow, overflow);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic                                i_cfg_index;
    logic [mair_pkg::CFG_DATA_W-1:0]     i_cfg_wdata;
    logic                                i_valid;
    logic                                o_ready;
    logic signed [mair_pkg::VALUE_W-1:0] i_value;
    logic                                i_last;
    logic                                o_valid;
    logic                                i_ready;
    logic signed [mair_pkg::VALUE_W-1:0] o_result_first;
    logic signed [mair_pkg::VALUE_W-1:0] o_result_second;
    logic                                o_result_missing;
    logic                                o_overflowed;

    t_set_aggregate_model agg;
    bit                   burst;
    int                   sent_items;
    int                   quiet_cycles;

    missing_aware_int64_reduction_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_value          (i_value),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_first   (o_result_first),
        .o_result_second  (o_result_second),
        .o_result_missing (o_result_missing),
        .o_overflowed     (o_overflowed)
    );

    // Clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sends one item after a random gap and returns at the falling edge after
    // it is accepted, with valid still high so that a following item can
    // reuse it without a drop.
    task automatic send_item(input logic signed [mair_pkg::VALUE_W-1:0] value,
                             input logic last_flag);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (burst || pick < 60) begin
            gap = 0;
        end else if (pick < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(6, 20);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        i_last  <= last_flag;
        do @(posedge i_clk); while (!o_ready);
        void'(agg.take_value(value, last_flag));
        sent_items++;
        @(negedge i_clk);
    endtask

    // Waits until every aggregate is in and the pipeline has gone quiet.
    task automatic drain();
        i_valid <= 1'b0;
        while (agg.pending_aggregates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input mair_pkg::t_cfg_reg idx, input logic [2:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        agg.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Receiver: runs of ready, short stalls and the odd long stall.
    initial begin
        int ready_hold;
        int pick;
        ready_hold = 0;
        i_ready    <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_hold == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    i_ready    <= 1'b1;
                    ready_hold = $urandom_range(1, 20);
                end else if (pick < 92) begin
                    i_ready    <= 1'b0;
                    ready_hold = $urandom_range(1, 3);
                end else begin
                    i_ready    <= 1'b0;
                    ready_hold = $urandom_range(8, 30);
                end
            end
            ready_hold--;
        end
    end

    // Result checking.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            agg.check_aggregate(o_result_first, o_result_second,
                                o_result_missing, o_overflowed);
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        int                                  phase;
        int                                  set_len;
        int                                  k;
        int                                  pick;
        int                                  offset;
        logic [31:0]                         word;
        logic [2:0]                          mode_sel;
        logic                                skip_sel;
        logic signed [mair_pkg::VALUE_W-1:0] v;

        agg          = new();
        burst        = 1'b0;
        sent_items   = 0;
        quiet_cycles = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= mair_pkg::REG_MODE;
        i_cfg_wdata <= '0;
        i_valid     <= 1'b0;
        i_value     <= '0;
        i_last      <= 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sum straight after reset: overflow at the top of the range, then a
        // missing value without skip.
        send_item(mair_pkg::POS_LIMIT, 1'b0);
        send_item(64'sd1, 1'b1);
        send_item(mair_pkg::MISSING_CODE, 1'b0);
        send_item(64'sd5, 1'b1);

        // Product: overflow at the bottom of the range, then a signed product.
        drain();
        write_reg(mair_pkg::REG_MODE, mair_pkg::MODE_PROD);
        send_item(mair_pkg::NEG_LIMIT, 1'b0);
        send_item(64'sd2, 1'b1);
        send_item(64'sd3, 1'b0);
        send_item(-64'sd5, 1'b1);

        // Range with skip: a set of only skipped values gives the identities.
        drain();
        write_reg(mair_pkg::REG_MODE, mair_pkg::MODE_RANGE);
        write_reg(mair_pkg::REG_SKIP, SKIP_ON);
        send_item(mair_pkg::MISSING_CODE, 1'b1);
        send_item(mair_pkg::NEG_LIMIT, 1'b0);
        send_item(mair_pkg::POS_LIMIT, 1'b1);

        // Min without skip: the missing value wins over later items.
        drain();
        write_reg(mair_pkg::REG_MODE, mair_pkg::MODE_MIN);
        write_reg(mair_pkg::REG_SKIP, SKIP_OFF);
        send_item(mair_pkg::MISSING_CODE, 1'b0);
        send_item(64'sd7, 1'b1);

        // Any: a deciding value after a missing one, then none at all.
        drain();
        write_reg(mair_pkg::REG_MODE, mair_pkg::MODE_ANY);
        send_item(mair_pkg::MISSING_CODE, 1'b0);
        send_item(64'sd0, 1'b0);
        send_item(64'sd9, 1'b1);
        send_item(mair_pkg::MISSING_CODE, 1'b0);
        send_item(64'sd0, 1'b1);

        // All: a zero decides even after a missing value.
        drain();
        write_reg(mair_pkg::REG_MODE, mair_pkg::MODE_ALL);
        send_item(64'sd1, 1'b0);
        send_item(mair_pkg::MISSING_CODE, 1'b0);
        send_item(64'sd0, 1'b1);

        // Max with skip.
        drain();
        write_reg(mair_pkg::REG_MODE, mair_pkg::MODE_MAX);
        write_reg(mair_pkg::REG_SKIP, SKIP_ON);
        send_item(mair_pkg::MISSING_CODE, 1'b0);
        send_item(-64'sd3, 1'b1);

        // The unused mode code acts as sum, and a register write throws away
        // the partial set.
        drain();
        write_reg(mair_pkg::REG_MODE, MODE_UNUSED);
        send_item(64'sd100, 1'b0);
        drain();
        write_reg(mair_pkg::REG_SKIP, SKIP_OFF);
        send_item(64'sd4, 1'b0);
        send_item(64'sd5, 1'b1);

        // Random phases: each mode once in order, then random settings.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase < 7) begin
                mode_sel = phase[2:0];
                skip_sel = phase[0];
            end else begin
                mode_sel = 3'($urandom_range(0, 7));
                skip_sel = 1'($urandom_range(0, 1));
            end
            drain();
            write_reg(mair_pkg::REG_MODE, mode_sel);
            write_reg(mair_pkg::REG_SKIP, {2'b00, skip_sel});
            burst = ($urandom_range(0, 3) == 0);
            while (sent_items < (phase + 1) * ITEMS_PER_PHASE) begin
                set_len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16)
                                                      : $urandom_range(1, 6);
                for (k = 0; k < set_len; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 6) begin
                        v = mair_pkg::MISSING_CODE;
                    end else if (pick < 12) begin
                        v = '0;
                    end else if (pick < 18) begin
                        case ($urandom_range(0, 3))
                            0:       v = mair_pkg::POS_LIMIT;
                            1:       v = mair_pkg::NEG_LIMIT;
                            2:       v = 64'sd1;
                            default: v = -64'sd1;
                        endcase
                    end else if (pick < 55) begin
                        offset = $urandom_range(0, 64);
                        v      = 64'(offset - 32);
                    end else if (pick < 75) begin
                        word = $urandom;
                        v    = {{32{word[31]}}, word};
                    end else begin
                        v = {$urandom, $urandom};
                    end
                    send_item(v, k == set_len - 1);
                end
            end
        end

        drain();
        if (agg.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
